@@ design/sqca_pkg.sv @@
// Shared types, widths and codes for the structured quad cell area block.
package sqca_pkg;

    // Field and register widths
    localparam int COORD_W     = 16;
    localparam int AREA_W      = 38;
    localparam int RV_W        = 11;
    localparam int RT_W        = 16;
    localparam int CNT_W       = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int ROW_MAX_DEF = 1024;

    // Arithmetic widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NORM_W = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int HALF_W = MAG_W / 2;
    localparam int PP_W   = 2 * HALF_W;
    localparam int SQ_W   = 2 * MAG_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int DOT_W  = SQ_W + 1;
    localparam int ITER_W = $clog2(ROOT_W + 1);

    // Job queue
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_VERTICES = 1'b0,
        REG_ROW_TOTAL    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vtx_t;

    typedef struct packed {
        vtx_t p1;
        vtx_t p2;
        vtx_t p3;
        vtx_t p4;
        logic last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic {
        FR_IDLE,
        FR_LOOK
    } front_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIFF,
        BK_CROSS,
        BK_NORM,
        BK_MUL,
        BK_ADD,
        BK_LOAD,
        BK_ROOT,
        BK_OUT
    } back_state_t;

endpackage

@@ design/sqca_front.sv @@
// Front end: configuration, grid counters, line buffer and quad assembly.
module sqca_front #(
    parameter int ROW_MAX = sqca_pkg::ROW_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sqca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sqca_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              vtx_valid,
    output logic                              vtx_ready,
    input  logic signed [sqca_pkg::COORD_W-1:0] x_coord,
    input  logic signed [sqca_pkg::COORD_W-1:0] y_coord,
    input  logic signed [sqca_pkg::COORD_W-1:0] z_coord,
    output logic                              job_push,
    output sqca_pkg::job_t                    job,
    input  sqca_pkg::fifo_stat_t              fifo_stat
);

    localparam int COL_W = $clog2(ROW_MAX);
    localparam int CW    = sqca_pkg::CNT_W;

    sqca_pkg::front_state_t state_reg, state_next;

    logic [sqca_pkg::RV_W-1:0] row_vertices_reg;
    logic [sqca_pkg::RT_W-1:0] row_total_reg;
    logic [COL_W-1:0]          col_reg;
    logic [sqca_pkg::RT_W-1:0] row_reg;
    sqca_pkg::vtx_t            prev_vertex_reg;

    sqca_pkg::vtx_t   p1_reg, p2_reg, p4_reg, rd_reg, vtx_in;
    logic             emit_reg, last_reg, end_reg;
    logic [COL_W-1:0] end_col_reg;

    logic [CW-1:0]    cols, rows, col_inc, row_inc;
    logic             row_end, grid_end, vtx_fire, look_done;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    sqca_pkg::vtx_t   mem_wdata;

    sqca_pkg::vtx_t line_mem [ROW_MAX];

    assign cfg_ready = 1'b1;
    assign vtx_in    = '{x: x_coord, y: y_coord, z: z_coord};
    assign vtx_fire  = vtx_valid && vtx_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vertices_reg <= sqca_pkg::RV_W'(2);
            row_total_reg    <= sqca_pkg::RT_W'(2);
        end
        else if (cfg_valid)
        begin
            unique case (sqca_pkg::cfg_reg_t'(cfg_index))
                sqca_pkg::REG_ROW_VERTICES: row_vertices_reg <= cfg_data[sqca_pkg::RV_W-1:0];
                sqca_pkg::REG_ROW_TOTAL:    row_total_reg    <= cfg_data[sqca_pkg::RT_W-1:0];
            endcase
        end
    end

    // Effective grid size and end-of-row / end-of-grid flags
    always_comb
    begin
        cols = CW'(row_vertices_reg);
        if (cols < CW'(2))
            cols = CW'(2);
        else if (cols > CW'(ROW_MAX))
            cols = CW'(ROW_MAX);
        rows = CW'(row_total_reg);
        if (rows < CW'(2))
            rows = CW'(2);
        col_inc  = CW'(col_reg) + CW'(1);
        row_inc  = CW'(row_reg) + CW'(1);
        row_end  = col_inc >= cols;
        grid_end = row_end && (row_inc >= rows);
    end

    // Grid counters and previous vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            prev_vertex_reg <= '0;
        end
        else if (vtx_fire)
        begin
            prev_vertex_reg <= vtx_in;
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= grid_end ? '0 : row_inc[sqca_pkg::RT_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // Per-beat holding registers
    always_ff @(posedge clk)
    begin
        if (vtx_fire)
        begin
            p4_reg      <= vtx_in;
            p2_reg      <= prev_vertex_reg;
            emit_reg    <= (col_reg != '0) && (row_reg != '0);
            last_reg    <= grid_end;
            end_reg     <= row_end;
            end_col_reg <= col_reg;
        end
        if (look_done)
            p1_reg <= rd_reg;
    end

    // Line buffer: one read on accept, one shared write port
    always_comb
    begin
        mem_we    = (vtx_fire && (col_reg != '0)) || (look_done && end_reg);
        mem_waddr = vtx_fire ? (col_reg - COL_W'(1)) : end_col_reg;
        mem_wdata = vtx_fire ? prev_vertex_reg : p4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (vtx_fire)
            rd_reg <= line_mem[col_reg];
        if (mem_we)
            line_mem[mem_waddr] <= mem_wdata;
    end

    // Job out to the queue
    always_comb
    begin
        job.p1   = p1_reg;
        job.p2   = p2_reg;
        job.p3   = rd_reg;
        job.p4   = p4_reg;
        job.last = last_reg;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sqca_pkg::FR_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        vtx_ready  = 1'b0;
        look_done  = 1'b0;
        job_push   = 1'b0;
        unique case (state_reg)
            sqca_pkg::FR_IDLE:
            begin
                vtx_ready = 1'b1;
                if (vtx_valid)
                    state_next = sqca_pkg::FR_LOOK;
            end
            sqca_pkg::FR_LOOK:
            begin
                if (!emit_reg || !fifo_stat.full)
                begin
                    look_done  = 1'b1;
                    job_push   = emit_reg;
                    state_next = sqca_pkg::FR_IDLE;
                end
            end
        endcase
    end

endmodule

@@ design/sqca_fifo.sv @@
// Short job queue between the front and back ends.
module sqca_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sqca_pkg::job_t       push_data,
    input  logic                 pop,
    output sqca_pkg::job_t       pop_data,
    output sqca_pkg::fifo_stat_t stat
);

    localparam int DEPTH = sqca_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sqca_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.full  = count_reg == CNT_W'(DEPTH);
    assign stat.empty = count_reg == '0;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ design/sqca_back.sv @@
// Back end: normals, squared norms, dot product, square roots and result register.
module sqca_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sqca_pkg::fifo_stat_t               fifo_stat,
    input  sqca_pkg::job_t                     job,
    output logic                               job_pop,
    output logic                               area_valid,
    input  logic                               area_ready,
    output logic signed [sqca_pkg::AREA_W-1:0] cell_area,
    output logic                               last_cell
);

    localparam int DW = sqca_pkg::DIFF_W;
    localparam int PW = sqca_pkg::PROD_W;
    localparam int NW = sqca_pkg::NORM_W;
    localparam int MW = sqca_pkg::MAG_W;
    localparam int HW = sqca_pkg::HALF_W;
    localparam int QW = sqca_pkg::PP_W;
    localparam int SW = sqca_pkg::SQ_W;
    localparam int RW = sqca_pkg::ROOT_W;
    localparam int EW = sqca_pkg::REM_W;
    localparam int TW = sqca_pkg::DOT_W;
    localparam int IW = sqca_pkg::ITER_W;
    localparam int AW = sqca_pkg::AREA_W;
    localparam int CO = sqca_pkg::COORD_W;

    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    sqca_pkg::back_state_t state_reg, state_next;

    sqca_pkg::job_t          job_reg;
    logic signed [DW-1:0]    d_reg    [4][3];
    logic signed [PW-1:0]    prod_reg [2][3][2];
    logic [MW-1:0]           mag_reg  [2][3];
    logic                    neg_reg  [2][3];
    logic [QW-1:0]           sq_hh_reg [2];
    logic [QW-1:0]           sq_hl_reg [2];
    logic [QW-1:0]           sq_ll_reg [2];
    logic [QW-1:0]           dt_hh_reg, dt_hl_reg, dt_lh_reg, dt_ll_reg;
    logic                    dneg_reg;
    logic [1:0]              k_reg;
    logic [SW-1:0]           sq_reg   [2];
    logic signed [TW-1:0]    dot_reg;
    logic [SW-1:0]           rad_reg  [2];
    logic [EW-1:0]           rem_reg  [2];
    logic [RW-1:0]           root_reg [2];
    logic [IW-1:0]           iter_reg;
    logic signed [AW-1:0]    area_reg;
    logic                    last_reg;
    logic                    area_valid_reg;

    logic signed [CO-1:0]    pc       [4][3];
    logic signed [NW-1:0]    nv       [2][3];
    logic [NW-1:0]           nabs     [2][3];
    logic [MW-1:0]           mk       [2];
    logic [SW-1:0]           dot_mag;
    logic [EW-1:0]           rem_t    [2];
    logic [EW-1:0]           trial    [2];
    logic [RW:0]             root_sum;
    logic                    out_load;

    function automatic logic signed [DW-1:0] sub_ext(input logic signed [CO-1:0] a,
                                                     input logic signed [CO-1:0] b);
        return $signed({a[CO-1], a}) - $signed({b[CO-1], b});
    endfunction

    assign area_valid = area_valid_reg;
    assign cell_area  = area_reg;
    assign last_cell  = last_reg;

    // Corner coordinates as an array: P1, P2, P3, P4
    always_comb
    begin
        pc[0] = '{job_reg.p1.x, job_reg.p1.y, job_reg.p1.z};
        pc[1] = '{job_reg.p2.x, job_reg.p2.y, job_reg.p2.z};
        pc[2] = '{job_reg.p3.x, job_reg.p3.y, job_reg.p3.z};
        pc[3] = '{job_reg.p4.x, job_reg.p4.y, job_reg.p4.z};
    end

    // Normal components, their magnitudes, selected component
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nv[i][k]   = $signed({prod_reg[i][k][0][PW-1], prod_reg[i][k][0]})
                           - $signed({prod_reg[i][k][1][PW-1], prod_reg[i][k][1]});
                nabs[i][k] = nv[i][k][NW-1] ? NW'(-nv[i][k]) : NW'(nv[i][k]);
            end
            mk[i] = mag_reg[i][k_reg];
        end
        dot_mag = (SW'(dt_hh_reg) << (2 * HW))
                + ((SW'(dt_hl_reg) + SW'(dt_lh_reg)) << HW)
                + SW'(dt_ll_reg);
    end

    // One root digit per cycle
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem_t[i] = {rem_reg[i][EW-3:0], rad_reg[i][SW-1 -: 2]};
            trial[i] = {root_reg[i], 2'b01};
        end
        root_sum = (RW + 1)'(root_reg[0]) + (RW + 1)'(root_reg[1]);
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sqca_pkg::BK_IDLE:
            begin
                if (job_pop)
                    job_reg <= job;
            end
            sqca_pkg::BK_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_reg[0][k] <= sub_ext(pc[0][k], pc[1][k]);
                    d_reg[1][k] <= sub_ext(pc[0][k], pc[2][k]);
                    d_reg[2][k] <= sub_ext(pc[3][k], pc[2][k]);
                    d_reg[3][k] <= sub_ext(pc[3][k], pc[1][k]);
                end
            end
            sqca_pkg::BK_CROSS:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        prod_reg[i][k][0] <= d_reg[2*i][NXT1[k]] * d_reg[2*i+1][NXT2[k]];
                        prod_reg[i][k][1] <= d_reg[2*i][NXT2[k]] * d_reg[2*i+1][NXT1[k]];
                    end
                end
            end
            sqca_pkg::BK_NORM:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[i][k] <= nabs[i][k][MW-1:0];
                        neg_reg[i][k] <= nv[i][k][NW-1];
                    end
                    sq_reg[i] <= '0;
                end
                dot_reg <= '0;
                k_reg   <= '0;
            end
            sqca_pkg::BK_MUL:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    sq_hh_reg[i] <= mk[i][MW-1:HW] * mk[i][MW-1:HW];
                    sq_hl_reg[i] <= mk[i][MW-1:HW] * mk[i][HW-1:0];
                    sq_ll_reg[i] <= mk[i][HW-1:0] * mk[i][HW-1:0];
                end
                dt_hh_reg <= mk[0][MW-1:HW] * mk[1][MW-1:HW];
                dt_hl_reg <= mk[0][MW-1:HW] * mk[1][HW-1:0];
                dt_lh_reg <= mk[0][HW-1:0] * mk[1][MW-1:HW];
                dt_ll_reg <= mk[0][HW-1:0] * mk[1][HW-1:0];
                dneg_reg  <= neg_reg[0][k_reg] ^ neg_reg[1][k_reg];
            end
            sqca_pkg::BK_ADD:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    sq_reg[i] <= sq_reg[i]
                               + (SW'(sq_hh_reg[i]) << (2 * HW))
                               + (SW'(sq_hl_reg[i]) << (HW + 1))
                               + SW'(sq_ll_reg[i]);
                end
                if (dneg_reg)
                    dot_reg <= dot_reg - $signed({1'b0, dot_mag});
                else
                    dot_reg <= dot_reg + $signed({1'b0, dot_mag});
                k_reg <= k_reg + 2'd1;
            end
            sqca_pkg::BK_LOAD:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    rad_reg[i]  <= sq_reg[i];
                    rem_reg[i]  <= '0;
                    root_reg[i] <= '0;
                end
                iter_reg <= IW'(RW - 1);
            end
            sqca_pkg::BK_ROOT:
            begin
                for (int i = 0; i < 2; i++)
                begin
                    rad_reg[i] <= rad_reg[i] << 2;
                    if (rem_t[i] >= trial[i])
                    begin
                        rem_reg[i]  <= rem_t[i] - trial[i];
                        root_reg[i] <= {root_reg[i][RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i]  <= rem_t[i];
                        root_reg[i] <= {root_reg[i][RW-2:0], 1'b0};
                    end
                end
                iter_reg <= iter_reg - IW'(1);
            end
            sqca_pkg::BK_OUT:
            begin
                if (out_load)
                begin
                    if (dot_reg < 0)
                        area_reg <= -$signed(AW'(root_sum));
                    else
                        area_reg <= $signed(AW'(root_sum));
                    last_reg <= job_reg.last;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            area_valid_reg <= 1'b0;
        else if (out_load)
            area_valid_reg <= 1'b1;
        else if (area_ready)
            area_valid_reg <= 1'b0;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sqca_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            sqca_pkg::BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    job_pop    = 1'b1;
                    state_next = sqca_pkg::BK_DIFF;
                end
            end
            sqca_pkg::BK_DIFF:  state_next = sqca_pkg::BK_CROSS;
            sqca_pkg::BK_CROSS: state_next = sqca_pkg::BK_NORM;
            sqca_pkg::BK_NORM:  state_next = sqca_pkg::BK_MUL;
            sqca_pkg::BK_MUL:   state_next = sqca_pkg::BK_ADD;
            sqca_pkg::BK_ADD:
            begin
                state_next = (k_reg == 2'd2) ? sqca_pkg::BK_LOAD : sqca_pkg::BK_MUL;
            end
            sqca_pkg::BK_LOAD:  state_next = sqca_pkg::BK_ROOT;
            sqca_pkg::BK_ROOT:
            begin
                if (iter_reg == '0)
                    state_next = sqca_pkg::BK_OUT;
            end
            sqca_pkg::BK_OUT:
            begin
                if (!area_valid_reg || area_ready)
                begin
                    out_load   = 1'b1;
                    state_next = sqca_pkg::BK_IDLE;
                end
            end
            default: state_next = sqca_pkg::BK_IDLE;
        endcase
    end

endmodule

@@ design/structured_quad_cell_area.sv @@
// Flow: the front end accepts a vertex and then looks up the line buffer before it takes the next;
// a closed quad waits there while the job queue is full. The back end pops the job and runs
// differences, cross products, normals, 3 x multiply/accumulate, 35 root digits and the output,
// and starts a new cell only once its result is loaded. A 2-deep job queue decouples the two ends.
// Reset: grid counters and previous vertex cleared, sizes back to 2 x 2; the line buffer is
// not cleared and holds nothing valid until a row has been written.
module structured_quad_cell_area #(
    parameter int ROW_MAX = sqca_pkg::ROW_MAX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sqca_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sqca_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 vtx_valid,
    output logic                                 vtx_ready,
    input  logic signed [sqca_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [sqca_pkg::COORD_W-1:0]  y_coord,
    input  logic signed [sqca_pkg::COORD_W-1:0]  z_coord,
    output logic                                 area_valid,
    input  logic                                 area_ready,
    output logic signed [sqca_pkg::AREA_W-1:0]   cell_area,
    output logic                                 last_cell
);

    logic                 job_push, job_pop;
    sqca_pkg::job_t       job_in, job_out;
    sqca_pkg::fifo_stat_t fifo_stat;

    // Vertex intake and quad assembly
    sqca_front #(
        .ROW_MAX (ROW_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .z_coord   (z_coord),
        .job_push  (job_push),
        .job       (job_in),
        .fifo_stat (fifo_stat)
    );

    // Job queue
    sqca_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .stat      (fifo_stat)
    );

    // Area computation
    sqca_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_stat  (fifo_stat),
        .job        (job_out),
        .job_pop    (job_pop),
        .area_valid (area_valid),
        .area_ready (area_ready),
        .cell_area  (cell_area),
        .last_cell  (last_cell)
    );

endmodule

@@ verif/structured_quad_cell_area_tb.sv @@
// Self-checking testbench for the structured quad cell area block.
`timescale 1ns / 100ps

module structured_quad_cell_area_tb;

    localparam int LINE_MAX    = 1024;
    localparam int DRAIN_WAIT  = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [sqca_pkg::AREA_W-1:0] area;
        logic                        last;
    } cell_t;

    typedef struct {
        sqca_pkg::vtx_t              v;
        bit                          typed;
        logic [sqca_pkg::AREA_W-1:0] area;
        logic                        last;
    } vec_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [sqca_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sqca_pkg::CFG_DATA_W-1:0] cfg_data;
    logic vtx_valid;
    logic vtx_ready;
    logic signed [sqca_pkg::COORD_W-1:0] x_coord;
    logic signed [sqca_pkg::COORD_W-1:0] y_coord;
    logic signed [sqca_pkg::COORD_W-1:0] z_coord;
    logic area_valid;
    logic area_ready;
    logic signed [sqca_pkg::AREA_W-1:0] cell_area;
    logic last_cell;

    // grid mirror
    sqca_pkg::vtx_t line_buf [LINE_MAX];
    sqca_pkg::vtx_t last_vtx;
    int unsigned col_idx;
    int unsigned row_idx;
    logic [sqca_pkg::RV_W-1:0] rv_reg;
    logic [sqca_pkg::RT_W-1:0] rt_reg;

    cell_t area_q[$];
    int errors;
    int cycles;
    bit long_hold;
    int burst_left;
    int vtx_count;

    structured_quad_cell_area uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .vtx_valid(vtx_valid), .vtx_ready(vtx_ready),
        .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
        .area_valid(area_valid), .area_ready(area_ready),
        .cell_area(cell_area), .last_cell(last_cell)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic int unsigned eff_cols();
        int unsigned c;
        c = (rv_reg < 2) ? 2 : rv_reg;
        return (c > LINE_MAX) ? LINE_MAX : c;
    endfunction

    function automatic int unsigned eff_rows();
        return (rt_reg < 2) ? 2 : rt_reg;
    endfunction

    function automatic logic [127:0] sq_norm(longint a, longint b, longint c);
        logic [127:0] ma, mb, mc;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        return ma * ma + mb * mb + mc * mc;
    endfunction

    // floored square root of a squared normal length
    function automatic logic [63:0] root_floor(logic [127:0] s);
        logic [127:0] r, t;
        r = 0;
        for (int b = 36; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t <= s)
                r = t;
        end
        return r[63:0];
    endfunction

    // advance the grid mirror by one vertex; returns 1 when a cell closes
    function automatic bit cell_from_vertex(sqca_pkg::vtx_t p4,
                                            output logic [sqca_pkg::AREA_W-1:0] area,
                                            output logic last);
        int unsigned cols, rows, c, r;
        bit row_end, grid_end, got;
        sqca_pkg::vtx_t p1, p2, p3;
        longint ax, ay, az, bx, by, bz, n1x, n1y, n1z, n2x, n2y, n2z;
        logic signed [127:0] dot;
        logic [63:0] sum;
        cols = eff_cols();
        rows = eff_rows();
        c = col_idx;
        r = row_idx;
        got = 0;
        area = '0;
        last = 1'b0;
        row_end = (c + 1 >= cols) || (c + 1 >= LINE_MAX);
        grid_end = row_end && (r + 1 >= rows);
        if (c >= 1 && c < LINE_MAX)
        begin
            if (r >= 1)
            begin
                p1 = line_buf[c-1];
                p3 = line_buf[c];
                p2 = last_vtx;
                ax = longint'(p1.x) - p2.x; ay = longint'(p1.y) - p2.y;
                az = longint'(p1.z) - p2.z;
                bx = longint'(p1.x) - p3.x; by = longint'(p1.y) - p3.y;
                bz = longint'(p1.z) - p3.z;
                n1x = ay * bz - az * by; n1y = az * bx - ax * bz; n1z = ax * by - ay * bx;
                ax = longint'(p4.x) - p3.x; ay = longint'(p4.y) - p3.y;
                az = longint'(p4.z) - p3.z;
                bx = longint'(p4.x) - p2.x; by = longint'(p4.y) - p2.y;
                bz = longint'(p4.z) - p2.z;
                n2x = ay * bz - az * by; n2y = az * bx - ax * bz; n2z = ax * by - ay * bx;
                sum = root_floor(sq_norm(n1x, n1y, n1z)) + root_floor(sq_norm(n2x, n2y, n2z));
                dot = 128'(n1x) * 128'(n2x) + 128'(n1y) * 128'(n2y)
                    + 128'(n1z) * 128'(n2z);
                if (dot < 0)
                    sum = -sum;
                area = sum[sqca_pkg::AREA_W-1:0];
                last = grid_end;
                got = 1;
            end
            line_buf[c-1] = last_vtx;
        end
        if (row_end && c < LINE_MAX)
            line_buf[c] = p4;
        last_vtx = p4;
        if (row_end)
        begin
            col_idx = 0;
            row_idx = grid_end ? 0 : ((r + 1) & 16'hFFFF);
        end
        else
            col_idx = c + 1;
        return got;
    endfunction

    // drive one vertex beat and queue its cell, if any
    task automatic send_vertex(sqca_pkg::vtx_t v, bit typed = 0,
                               logic [sqca_pkg::AREA_W-1:0] t_area = '0,
                               logic t_last = 1'b0);
        logic [sqca_pkg::AREA_W-1:0] a;
        logic l;
        cell_t e;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0)
            begin
                vtx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        vtx_valid <= 1'b1;
        x_coord <= v.x;
        y_coord <= v.y;
        z_coord <= v.z;
        do @(posedge clk); while (!vtx_ready);
        vtx_count++;
        if (cell_from_vertex(v, a, l))
        begin
            e.area = typed ? t_area : a;
            e.last = typed ? t_last : l;
            area_q.push_back(e);
        end
    endtask

    task automatic wait_drained();
        vtx_valid <= 1'b0;
        do @(posedge clk); while (area_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(sqca_pkg::cfg_reg_t idx, logic [sqca_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sqca_pkg::REG_ROW_VERTICES)
            rv_reg = val[sqca_pkg::RV_W-1:0];
        else
            rt_reg = val;
        @(posedge clk);
    endtask

    function automatic sqca_pkg::vtx_t rand_vertex(int unsigned c, int unsigned r, int step);
        sqca_pkg::vtx_t v;
        if ($urandom_range(0, 4) == 0)
        begin
            v.x = 16'($urandom); v.y = 16'($urandom); v.z = 16'($urandom);
        end
        else
        begin
            v.x = 16'(int'(c) * step + $urandom_range(0, 63) - 32);
            v.y = 16'(int'(r) * step + $urandom_range(0, 63) - 32);
            v.z = 16'($urandom_range(0, 511) - 256);
        end
        return v;
    endfunction

    task automatic finish_grid(int step);
        do send_vertex(rand_vertex(col_idx, row_idx, step));
        while (col_idx != 0 || row_idx != 0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        cell_t e;
        if (rst_n && area_valid && area_ready)
        begin
            if (area_q.size() == 0)
            begin
                $display("%0t: unexpected cell beat area=%0d last=%0b", $time, cell_area,
                         last_cell);
                errors++;
            end
            else
            begin
                e = area_q.pop_front();
                if (cell_area !== e.area)
                begin
                    $display("%0t: cell_area expected %0d got %0d", $time,
                             $signed(e.area), cell_area);
                    errors++;
                end
                if (last_cell !== e.last)
                begin
                    $display("%0t: last_cell expected %0b got %0b", $time, e.last, last_cell);
                    errors++;
                end
            end
        end
    end

    // receiver: stall pattern in stretches, plus one long hold on request
    initial
    begin
        int mode;
        area_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                area_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 0;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                repeat ($urandom_range(20, 150))
                begin
                    if (long_hold)
                        break;
                    case (mode)
                        0: area_ready <= 1'b1;
                        1: area_ready <= $urandom_range(0, 1);
                        default: area_ready <= ($urandom_range(0, 5) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        vec_row_t dir_tab[$];
        vec_row_t t;
        int step;
        int unsigned rv;
        errors = 0; vtx_count = 0; burst_left = 0; long_hold = 0;
        cfg_valid = 1'b0; cfg_index = sqca_pkg::REG_ROW_VERTICES; cfg_data = '0;
        vtx_valid = 1'b0; x_coord = '0; y_coord = '0; z_coord = '0;
        rv_reg = 2; rt_reg = 2; col_idx = 0; row_idx = 0; last_vtx = '0;
        foreach (line_buf[i]) line_buf[i] = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed 2 x 2 grids after reset: 256-side square, full-range square, degenerate
        dir_tab = '{
            '{'{16'sd0, 16'sd0, 16'sd0}, 0, 0, 0},
            '{'{16'sd256, 16'sd0, 16'sd0}, 0, 0, 0},
            '{'{16'sd0, 16'sd256, 16'sd0}, 0, 0, 0},
            '{'{16'sd256, 16'sd256, 16'sd0}, 1, 38'd131072, 1'b1},
            '{'{-16'sd32768, -16'sd32768, 16'sd0}, 0, 0, 0},
            '{'{16'sd32767, -16'sd32768, 16'sd0}, 0, 0, 0},
            '{'{-16'sd32768, 16'sd32767, 16'sd0}, 0, 0, 0},
            '{'{16'sd32767, 16'sd32767, 16'sd0}, 1, 38'd8589672450, 1'b1},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 0, 0, 0},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 0, 0, 0},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 0, 0, 0},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1, 38'd0, 1'b1},
            '{'{-16'sd32768, 16'sd32767, -16'sd32768}, 0, 0, 0},
            '{'{16'sd32767, -16'sd32768, 16'sd32767}, 0, 0, 0},
            '{'{16'sd32767, 16'sd32767, -16'sd32768}, 0, 0, 0},
            '{'{-16'sd32768, -16'sd32768, 16'sd32767}, 0, 0, 0},
            '{'{16'sd0, 16'sd0, 16'sd0}, 0, 0, 0},
            '{'{16'sd256, 16'sd0, 16'sd0}, 0, 0, 0},
            '{'{16'sd256, 16'sd0, 16'sd0}, 0, 0, 0},
            '{'{16'sd0, 16'sd0, 16'sd256}, 0, 0, 0}
        };
        foreach (dir_tab[i])
        begin
            t = dir_tab[i];
            send_vertex(t.v, t.typed, t.area, t.last);
        end
        wait_drained();

        // widest row (out-of-range size acts as the line maximum), then a narrow second row
        write_reg(sqca_pkg::REG_ROW_VERTICES, 16'hFFFF);
        write_reg(sqca_pkg::REG_ROW_TOTAL, 16'd0);
        do send_vertex(rand_vertex(col_idx, row_idx, 64));
        while (col_idx != 0);
        wait_drained();
        write_reg(sqca_pkg::REG_ROW_VERTICES, 16'd2);
        finish_grid(64);
        wait_drained();

        // tallest grid, cut short mid-grid by shrinking both sizes
        write_reg(sqca_pkg::REG_ROW_VERTICES, 16'd5);
        write_reg(sqca_pkg::REG_ROW_TOTAL, 16'd65535);
        repeat (17) send_vertex(rand_vertex(col_idx, row_idx, 300));
        wait_drained();
        write_reg(sqca_pkg::REG_ROW_VERTICES, 16'd3);
        write_reg(sqca_pkg::REG_ROW_TOTAL, 16'd1);
        finish_grid(300);

        // random grids, drained between phases; one long receiver hold on an 8 x 5 grid
        for (int ph = 0; vtx_count < 1150 || ph < 4; ph++)
        begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: rv = $urandom_range(0, 1);
                1: rv = $urandom_range(13, 40);
                default: rv = $urandom_range(2, 12);
            endcase
            if (ph == 3)
                rv = 8;
            write_reg(sqca_pkg::REG_ROW_VERTICES, 16'(rv | ($urandom_range(0, 1) << 11)));
            write_reg(sqca_pkg::REG_ROW_TOTAL, 16'((ph == 3) ? 5 : $urandom_range(0, 7)));
            step = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8000) : $urandom_range(8, 400);
            if (ph == 3)
                long_hold = 1;
            finish_grid(step);
            if (ph % 4 == 1)
            begin
                // mid-grid row count change is safe at any point
                repeat ($urandom_range(1, 12)) send_vertex(rand_vertex(col_idx, row_idx, step));
                wait_drained();
                write_reg(sqca_pkg::REG_ROW_TOTAL, 16'($urandom_range(0, 5)));
                if (col_idx != 0 || row_idx != 0)
                    finish_grid(step);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
